// ===== hdl/esd_pkg.sv =====
// Shared types and constants of the event subscription dispatcher.
// Used by esd_cell, esd_chain and event_subscription_dispatcher_top.
`default_nettype none

package esd_pkg;

    // Default sizing of the subscriber table
    localparam int DEF_MAX_SUBSCRIBERS = 16;
    localparam int DEF_EVENT_TYPES     = 32;

    // Field widths of the request and result channels
    localparam int REQ_W    = 2;
    localparam int SVC_W    = 8;
    localparam int EVT_W    = 5;
    localparam int MASKIN_W = 32;
    localparam int STATUS_W = 3;

    // Request types
    localparam logic [REQ_W-1:0] REQ_PUBLISH     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUBSCRIBE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNSUBSCRIBE = 2'd2;

    // Result kinds
    localparam logic KIND_NOTIFY = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_ALREADY   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_STATUS
    } esd_state_t;

    // Per-cell control: rotate one place, take from the head, load a new entry
    typedef struct packed {
        logic shift;
        logic wrap;
        logic load;
    } esd_cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/event_subscription_dispatcher_top.sv =====
// Event subscription dispatcher: request channel in, result channel out.
// Depends on esd_pkg and esd_chain (which instantiates esd_cell).
//
// Usage: a request (publish, subscribe or unsubscribe) enters on req_valid
// while req_stall is low. Results leave on res_valid and are taken when
// res_stall is low; a publish gives one notification per matching
// subscriber (none if nothing matches), the others give one status result.
// The final result of each request carries last_result.
// Scan: with n subscribers stored, a request rotates the cell ring once
// over the occupied cells, one cell per cycle while no held notification
// waits on a stalled receiver; the result then goes through the result
// register. A subscribe to a full table skips the scan.
// Throughput: one request at a time; req_stall is high while a request is
// scanned or its last result waits for the output register. A new request
// is taken while the previous final result still sits in that register.
// A stalled receiver holds the scan whenever a further result is ready.
// Reset empties the table at once; the entries themselves are not cleared.
`default_nettype none

module event_subscription_dispatcher_top #(
    parameter int MAX_SUBSCRIBERS = esd_pkg::DEF_MAX_SUBSCRIBERS,
    parameter int EVENT_TYPES     = esd_pkg::DEF_EVENT_TYPES
) (
    input  wire                             clk,
    input  wire                             rst_n,
    // request channel
    input  wire                             req_valid,
    output logic                            req_stall,
    input  wire [esd_pkg::REQ_W-1:0]        req_type,
    input  wire [esd_pkg::SVC_W-1:0]        service_id,
    input  wire [esd_pkg::EVT_W-1:0]        event_code,
    input  wire [esd_pkg::MASKIN_W-1:0]     event_mask,
    // result channel
    output logic                            res_valid,
    input  wire                             res_stall,
    output logic                            result_kind,
    output logic [esd_pkg::SVC_W-1:0]       target_service,
    output logic [esd_pkg::EVT_W-1:0]       notified_event,
    output logic [esd_pkg::STATUS_W-1:0]    status_code,
    output logic                            last_result
);

    localparam int MASK_W = (EVENT_TYPES < esd_pkg::MASKIN_W) ? EVENT_TYPES
                                                               : esd_pkg::MASKIN_W;
    localparam int IDX_W  = $clog2(MASK_W);
    localparam int CNT_W  = $clog2(MAX_SUBSCRIBERS + 1);

    // State and request registers
    esd_pkg::esd_state_t state_reg, state_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             remaining_reg;
    logic                         found_reg;
    logic                         full_reg;
    logic [esd_pkg::REQ_W-1:0]    req_reg;
    logic [esd_pkg::SVC_W-1:0]    svc_reg;
    logic [esd_pkg::EVT_W-1:0]    ev_reg;
    logic [MASK_W-1:0]            mask_reg;

    // Held notification, waiting to learn whether it is the last
    logic                         pend_valid_reg;
    logic [esd_pkg::SVC_W-1:0]    pend_service_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         out_kind_reg;
    logic [esd_pkg::SVC_W-1:0]    out_target_reg;
    logic [esd_pkg::EVT_W-1:0]    out_event_reg;
    logic [esd_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;

    // Chain interface
    logic [esd_pkg::SVC_W-1:0]    head_service;
    logic [MASK_W-1:0]            head_mask;

    // Control signals
    logic                         accept;
    logic                         out_free;
    logic                         ev_ok;
    logic                         is_pub;
    logic                         is_sub;
    logic                         is_unsub;
    logic                         scan_done;
    logic                         head_hit;
    logic                         head_match;
    logic                         step;
    logic                         load_entry;
    logic                         count_inc;
    logic                         count_dec;
    logic                         set_found;
    logic                         pend_set;
    logic                         pend_clr;
    logic                         out_load;
    logic                         out_kind_next;
    logic [esd_pkg::SVC_W-1:0]    out_target_next;
    logic [esd_pkg::EVT_W-1:0]    out_event_next;
    logic [esd_pkg::STATUS_W-1:0] out_status_next;
    logic                         out_last_next;
    logic [esd_pkg::STATUS_W-1:0] status_value;

    assign req_stall  = (state_reg != esd_pkg::ST_IDLE);
    assign accept     = req_valid && !req_stall;
    assign out_free   = !out_valid_reg || !res_stall;
    assign ev_ok      = (32'(event_code) < EVENT_TYPES);
    assign is_pub     = (req_reg == esd_pkg::REQ_PUBLISH);
    assign is_sub     = (req_reg == esd_pkg::REQ_SUBSCRIBE);
    assign is_unsub   = (req_reg == esd_pkg::REQ_UNSUBSCRIBE);
    assign scan_done  = (remaining_reg == '0);
    assign head_hit   = head_mask[ev_reg[IDX_W-1:0]];
    assign head_match = (head_service == svc_reg);

    // Status of a subscribe or unsubscribe once the scan is over
    always_comb
    begin
        if (is_sub)
        begin
            if (full_reg)
                status_value = esd_pkg::STS_FULL;
            else if (found_reg)
                status_value = esd_pkg::STS_ALREADY;
            else
                status_value = esd_pkg::STS_ADDED;
        end
        else
        begin
            status_value = found_reg ? esd_pkg::STS_REMOVED : esd_pkg::STS_NOT_FOUND;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        esd_pkg::REQ_PUBLISH:
                            state_next = ev_ok ? esd_pkg::ST_SCAN : esd_pkg::ST_IDLE;
                        esd_pkg::REQ_SUBSCRIBE:
                            state_next = (count_reg >= CNT_W'(MAX_SUBSCRIBERS))
                                         ? esd_pkg::ST_STATUS : esd_pkg::ST_SCAN;
                        esd_pkg::REQ_UNSUBSCRIBE:
                            state_next = esd_pkg::ST_SCAN;
                        default:
                            state_next = esd_pkg::ST_IDLE;
                    endcase
                end
            end
            esd_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (is_pub)
                        state_next = pend_valid_reg ? esd_pkg::ST_FLUSH : esd_pkg::ST_IDLE;
                    else
                        state_next = esd_pkg::ST_STATUS;
                end
            end
            esd_pkg::ST_FLUSH:
            begin
                if (out_free)
                    state_next = esd_pkg::ST_IDLE;
            end
            esd_pkg::ST_STATUS:
            begin
                if (out_free)
                    state_next = esd_pkg::ST_IDLE;
            end
            default:
                state_next = esd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        step            = 1'b0;
        load_entry      = 1'b0;
        count_inc       = 1'b0;
        count_dec       = 1'b0;
        set_found       = 1'b0;
        pend_set        = 1'b0;
        pend_clr        = 1'b0;
        out_load        = 1'b0;
        out_kind_next   = esd_pkg::KIND_NOTIFY;
        out_target_next = pend_service_reg;
        out_event_next  = ev_reg;
        out_status_next = esd_pkg::STS_ADDED;
        out_last_next   = 1'b0;
        unique case (state_reg)
            esd_pkg::ST_IDLE:
            begin
                step = 1'b0;
            end
            esd_pkg::ST_SCAN:
            begin
                if (!scan_done)
                begin
                    if (is_pub)
                    begin
                        // Hold the ring while a second match cannot push out the first
                        step = !(head_hit && pend_valid_reg && !out_free);
                        if (step && head_hit)
                        begin
                            pend_set = 1'b1;
                            out_load = pend_valid_reg;
                        end
                    end
                    else
                    begin
                        step = 1'b1;
                        if (head_match && !found_reg)
                        begin
                            set_found = 1'b1;
                            // Drop the first match by shrinking the ring under it
                            count_dec = is_unsub;
                        end
                    end
                end
                else if (is_sub && !found_reg)
                begin
                    load_entry = 1'b1;
                    count_inc  = 1'b1;
                end
            end
            esd_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    pend_clr      = 1'b1;
                end
            end
            esd_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = esd_pkg::KIND_STATUS;
                    out_target_next = svc_reg;
                    out_event_next  = '0;
                    out_status_next = status_value;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
                step = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= esd_pkg::ST_IDLE;
            count_reg      <= '0;
            remaining_reg  <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (count_inc)
                count_reg <= count_reg + 1'b1;
            else if (count_dec)
                count_reg <= count_reg - 1'b1;
            if (accept)
                remaining_reg <= count_reg;
            else if (step)
                remaining_reg <= remaining_reg - 1'b1;
            if (accept)
                found_reg <= 1'b0;
            else if (set_found)
                found_reg <= 1'b1;
            if (pend_set)
                pend_valid_reg <= 1'b1;
            else if (pend_clr)
                pend_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            svc_reg  <= service_id;
            ev_reg   <= event_code;
            mask_reg <= event_mask[MASK_W-1:0];
            full_reg <= (count_reg >= CNT_W'(MAX_SUBSCRIBERS));
        end
        if (pend_set)
            pend_service_reg <= head_service;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg   <= out_kind_next;
            out_target_reg <= out_target_next;
            out_event_reg  <= out_event_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    esd_chain #(
        .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS),
        .MASK_W          (MASK_W),
        .CNT_W           (CNT_W)
    ) u_chain (
        .clk          (clk),
        .shift        (step),
        .load         (load_entry),
        .count        (count_reg),
        .new_service  (svc_reg),
        .new_mask     (mask_reg),
        .head_service (head_service),
        .head_mask    (head_mask)
    );

    assign res_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign target_service = out_target_reg;
    assign notified_event = out_event_reg;
    assign status_code    = out_status_reg;
    assign last_result    = out_last_reg;

    // Table never holds more than its capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SUBSCRIBERS))
        else $error("subscriber count beyond capacity");

    // Rotation never runs past the occupied cells
    a_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == esd_pkg::ST_SCAN) |-> (remaining_reg <= count_reg))
        else $error("scan counter exceeds subscriber count");

    // Count changes only during a scan
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == esd_pkg::ST_SCAN))
        else $error("subscriber count changed outside a scan");

    // A status result always closes its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == esd_pkg::KIND_STATUS)) |-> out_last_reg)
        else $error("status result without last flag");

endmodule

`default_nettype wire

// ===== hdl/esd_cell.sv =====
// One subscriber table cell: holds a service id and its event mask.
// Depends on esd_pkg for the cell control struct and the field widths.
`default_nettype none

module esd_cell #(
    parameter int MASK_W = esd_pkg::DEF_EVENT_TYPES
) (
    input  wire                         clk,
    input  wire esd_pkg::esd_cell_ctl_t ctl,
    input  wire [esd_pkg::SVC_W-1:0]    nb_service,
    input  wire [MASK_W-1:0]            nb_mask,
    input  wire [esd_pkg::SVC_W-1:0]    head_service,
    input  wire [MASK_W-1:0]            head_mask,
    input  wire [esd_pkg::SVC_W-1:0]    new_service,
    input  wire [MASK_W-1:0]            new_mask,
    output logic [esd_pkg::SVC_W-1:0]   service,
    output logic [MASK_W-1:0]           mask
);

    logic [esd_pkg::SVC_W-1:0] service_reg;
    logic [MASK_W-1:0]         mask_reg;

    // Load a new entry, or take the neighbour's (or the head's) entry on a rotate
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            service_reg <= new_service;
            mask_reg    <= new_mask;
        end
        else if (ctl.shift)
        begin
            service_reg <= ctl.wrap ? head_service : nb_service;
            mask_reg    <= ctl.wrap ? head_mask    : nb_mask;
        end
    end

    assign service = service_reg;
    assign mask    = mask_reg;

endmodule

`default_nettype wire

// ===== hdl/esd_chain.sv =====
// Row of subscriber cells forming a ring over the occupied entries.
// Depends on esd_pkg and esd_cell.
`default_nettype none

module esd_chain #(
    parameter int MAX_SUBSCRIBERS = esd_pkg::DEF_MAX_SUBSCRIBERS,
    parameter int MASK_W          = esd_pkg::DEF_EVENT_TYPES,
    parameter int CNT_W           = $clog2(MAX_SUBSCRIBERS + 1)
) (
    input  wire                         clk,
    input  wire                         shift,
    input  wire                         load,
    input  wire [CNT_W-1:0]             count,
    input  wire [esd_pkg::SVC_W-1:0]    new_service,
    input  wire [MASK_W-1:0]            new_mask,
    output logic [esd_pkg::SVC_W-1:0]   head_service,
    output logic [MASK_W-1:0]           head_mask
);

    logic [esd_pkg::SVC_W-1:0] svc_q  [MAX_SUBSCRIBERS];
    logic [MASK_W-1:0]         mask_q [MAX_SUBSCRIBERS];

    assign head_service = svc_q[0];
    assign head_mask    = mask_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SUBSCRIBERS; gi++)
        begin : g_cell
            esd_pkg::esd_cell_ctl_t    ctl;
            logic [esd_pkg::SVC_W-1:0] nb_svc;
            logic [MASK_W-1:0]         nb_mask;

            // Rotate only the occupied cells; the last occupied one takes the head
            assign ctl.shift = shift && (CNT_W'(gi) < count);
            assign ctl.wrap  = (CNT_W'(gi + 1) == count);
            assign ctl.load  = load && (CNT_W'(gi) == count);

            if (gi == MAX_SUBSCRIBERS - 1)
            begin : g_last
                assign nb_svc  = svc_q[0];
                assign nb_mask = mask_q[0];
            end
            else
            begin : g_mid
                assign nb_svc  = svc_q[gi + 1];
                assign nb_mask = mask_q[gi + 1];
            end

            esd_cell #(
                .MASK_W (MASK_W)
            ) u_cell (
                .clk          (clk),
                .ctl          (ctl),
                .nb_service   (nb_svc),
                .nb_mask      (nb_mask),
                .head_service (svc_q[0]),
                .head_mask    (mask_q[0]),
                .new_service  (new_service),
                .new_mask     (new_mask),
                .service      (svc_q[gi]),
                .mask         (mask_q[gi])
            );
        end
    endgenerate

endmodule

`default_nettype wire
